// ----- src/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared constants, types and character tables for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    // expression characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_POW    = 8'h5E;

    // stack entry codes
    localparam logic [2:0] CODE_LPAREN = 3'd0;
    localparam logic [2:0] CODE_PLUS   = 3'd1;
    localparam logic [2:0] CODE_MINUS  = 3'd2;
    localparam logic [2:0] CODE_MUL    = 3'd3;
    localparam logic [2:0] CODE_DIV    = 3'd4;
    localparam logic [2:0] CODE_MOD    = 3'd5;
    localparam logic [2:0] CODE_POW    = 3'd6;
    localparam logic [2:0] CODE_NONE   = 3'd7;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EMIT   = 6'b000010,
        ST_POP_RD = 6'b000100,
        ST_POP_EX = 6'b001000,
        ST_FIN    = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        MODE_CLOSE = 3'b001,
        MODE_OP    = 3'b010,
        MODE_FLUSH = 3'b100
    } mode_t;

    // request from the sequencer to the output stage
    typedef struct packed {
        logic       emit;
        logic       fin;
        logic       held;
        logic [7:0] ch;
        logic       ovf;
    } out_req_t;

    typedef struct packed {
        logic emit_ok;
        logic fin_ok;
    } out_ack_t;

    function automatic logic [2:0] f_op_code(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CH_PLUS:  code = CODE_PLUS;
            CH_MINUS: code = CODE_MINUS;
            CH_MUL:   code = CODE_MUL;
            CH_DIV:   code = CODE_DIV;
            CH_MOD:   code = CODE_MOD;
            CH_POW:   code = CODE_POW;
            default:  code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] f_code_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_LPAREN: c = CH_LPAREN;
            CODE_PLUS:   c = CH_PLUS;
            CODE_MINUS:  c = CH_MINUS;
            CODE_MUL:    c = CH_MUL;
            CODE_DIV:    c = CH_DIV;
            CODE_MOD:    c = CH_MOD;
            CODE_POW:    c = CH_POW;
            default:     c = 8'h00;
        endcase
        return c;
    endfunction

    // '(' ranks below every operator
    function automatic logic [1:0] f_prec(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            CODE_PLUS, CODE_MINUS:          p = 2'd1;
            CODE_MUL, CODE_DIV, CODE_MOD:   p = 2'd2;
            CODE_POW:                       p = 2'd3;
            default:                        p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ----- src/ipc_out_stage.sv -----
// ----------------------------------------------------------------------------
// ipc_out_stage
// Result register and hold slot. During an end-of-expression item results
// are kept one behind so that the final one can carry the last flag.
// ----------------------------------------------------------------------------
module ipc_out_stage
    import ipc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  out_req_t   req_i,
    output out_ack_t   ack_o,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // char_out
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [1] overflow, [0] no_char
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       none_reg, none_next;
    logic       ovf_reg, ovf_next;
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_ch_reg, hold_ch_next;
    logic       hold_ovf_reg, hold_ovf_next;
    logic       out_free;

    assign out_free      = !valid_reg || m_tready;
    assign ack_o.emit_ok = req_i.held ? (!hold_valid_reg || out_free) : out_free;
    assign ack_o.fin_ok  = out_free;

    always_comb begin
        valid_next      = valid_reg && !m_tready;
        data_next       = data_reg;
        last_next       = last_reg;
        none_next       = none_reg;
        ovf_next        = ovf_reg;
        hold_valid_next = hold_valid_reg;
        hold_ch_next    = hold_ch_reg;
        hold_ovf_next   = hold_ovf_reg;
        if (req_i.emit && ack_o.emit_ok) begin
            if (!req_i.held) begin
                valid_next = 1'b1;
                data_next  = req_i.ch;
                last_next  = 1'b0;
                none_next  = 1'b0;
                ovf_next   = req_i.ovf;
            end else begin
                if (hold_valid_reg) begin
                    valid_next = 1'b1;
                    data_next  = hold_ch_reg;
                    last_next  = 1'b0;
                    none_next  = 1'b0;
                    ovf_next   = hold_ovf_reg;
                end
                hold_valid_next = 1'b1;
                hold_ch_next    = req_i.ch;
                hold_ovf_next   = req_i.ovf;
            end
        end else if (req_i.fin && out_free) begin
            valid_next      = 1'b1;
            last_next       = 1'b1;
            hold_valid_next = 1'b0;
            if (hold_valid_reg) begin
                data_next = hold_ch_reg;
                none_next = 1'b0;
                ovf_next  = hold_ovf_reg;
            end else begin
                // nothing came out: bare end marker
                data_next = 8'h00;
                none_next = 1'b1;
                ovf_next  = req_i.ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg     <= data_next;
        last_reg     <= last_next;
        none_reg     <= none_next;
        ovf_reg      <= ovf_next;
        hold_ch_reg  <= hold_ch_next;
        hold_ovf_reg <= hold_ovf_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {ovf_reg, none_reg};

endmodule

// ----- src/infix_to_postfix_converter.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// One character is taken per item (s_tdata), with s_tlast marking the end of
// the expression. Spaces and '(' are handled in ST_IDLE and ordinary
// characters pass through ST_EMIT. Every stack pop passes through ST_POP_RD
// and ST_POP_EX, because the operator stack is a memory with one write port
// and a registered read: ST_POP_RD addresses the top entry and ST_POP_EX
// decides and emits. An operator pops entries until the stack runs empty or
// it stops on a lower entry; ')' likewise, stopping on its '('. An end item
// flushes the stack and then gives the closing result. Results during an end
// item are held one behind so the final one carries m_tlast; an end item that
// produces nothing gives a single marker with no_char set. Pushes onto a
// full stack are dropped and set a sticky overflow flag, reported with each
// result in m_tuser. The input is not ready while an item is being worked.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import ipc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // char_out
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [1] overflow, [0] no_char
);

    state_t           state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [7:0]       char_reg, char_next;
    logic             end_reg, end_next;
    logic [2:0]       opc_reg, opc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic [2:0]       rd_data_reg;

    logic [2:0]       stack_mem [STACK_DEPTH];
    logic             wr_en;
    logic [2:0]       wr_data;
    logic [PTR_W-1:0] rd_addr;
    logic [CNT_W-1:0] count_dec;

    out_req_t         req;
    out_ack_t         ack;
    logic             in_fire;
    logic [2:0]       in_code;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign in_code   = f_op_code(s_tdata);
    assign count_dec = count_reg - CNT_W'(1);
    assign rd_addr   = count_dec[PTR_W-1:0];

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        char_next     = char_reg;
        end_next      = end_reg;
        opc_next      = opc_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        wr_en         = 1'b0;
        wr_data       = CODE_LPAREN;
        req.emit      = 1'b0;
        req.fin       = 1'b0;
        req.held      = end_reg;
        req.ch        = f_code_char(rd_data_reg);
        req.ovf       = overflow_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    char_next = s_tdata;
                    end_next  = s_tlast;
                    opc_next  = in_code;
                    if (s_tdata == CH_SPACE || s_tdata == CH_LPAREN) begin
                        if (s_tdata == CH_LPAREN) begin
                            wr_data = CODE_LPAREN;
                            if (count_reg == CNT_FULL) begin
                                overflow_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        if (s_tlast) begin
                            mode_next  = MODE_FLUSH;
                            state_next = ST_POP_RD;
                        end
                    end else if (s_tdata == CH_RPAREN) begin
                        mode_next  = MODE_CLOSE;
                        state_next = ST_POP_RD;
                    end else if (in_code != CODE_NONE) begin
                        mode_next  = MODE_OP;
                        state_next = ST_POP_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT: begin
                req.emit = 1'b1;
                req.ch   = char_reg;
                if (ack.emit_ok) begin
                    mode_next  = MODE_FLUSH;
                    state_next = end_reg ? ST_POP_RD : ST_IDLE;
                end
            end

            ST_POP_RD: begin
                if (count_reg != '0) begin
                    state_next = ST_POP_EX;
                end else begin
                    case (mode_reg)
                        MODE_FLUSH: state_next = ST_FIN;
                        MODE_OP: begin
                            // stack empty: the operator goes straight on
                            wr_en      = 1'b1;
                            wr_data    = opc_reg;
                            count_next = count_reg + CNT_W'(1);
                            mode_next  = MODE_FLUSH;
                            state_next = end_reg ? ST_POP_RD : ST_IDLE;
                        end
                        default: begin
                            mode_next  = MODE_FLUSH;
                            state_next = end_reg ? ST_POP_RD : ST_IDLE;
                        end
                    endcase
                end
            end

            ST_POP_EX: begin
                case (mode_reg)
                    MODE_CLOSE: begin
                        if (rd_data_reg == CODE_LPAREN) begin
                            count_next = count_dec;
                            mode_next  = MODE_FLUSH;
                            state_next = end_reg ? ST_POP_RD : ST_IDLE;
                        end else begin
                            req.emit = 1'b1;
                            if (ack.emit_ok) begin
                                count_next = count_dec;
                                state_next = ST_POP_RD;
                            end
                        end
                    end
                    MODE_OP: begin
                        if (f_prec(rd_data_reg) >= f_prec(opc_reg)) begin
                            req.emit = 1'b1;
                            if (ack.emit_ok) begin
                                count_next = count_dec;
                                state_next = ST_POP_RD;
                            end
                        end else begin
                            wr_data = opc_reg;
                            if (count_reg == CNT_FULL) begin
                                overflow_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            mode_next  = MODE_FLUSH;
                            state_next = end_reg ? ST_POP_RD : ST_IDLE;
                        end
                    end
                    default: begin
                        // flush drops stacked '(' silently
                        if (rd_data_reg == CODE_LPAREN) begin
                            count_next = count_dec;
                            state_next = ST_POP_RD;
                        end else begin
                            req.emit = 1'b1;
                            if (ack.emit_ok) begin
                                count_next = count_dec;
                                state_next = ST_POP_RD;
                            end
                        end
                    end
                endcase
            end

            ST_FIN: begin
                req.fin = 1'b1;
                if (ack.fin_ok) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_FLUSH;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        end_reg  <= end_next;
        opc_reg  <= opc_next;
    end

    // operator stack, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[count_reg[PTR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    ipc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_i    (req),
        .ack_o    (ack),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("stack count beyond depth");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    a_fin_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN |-> count_reg == '0)
        else $error("closing result with operators still stacked");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("end marker malformed");

endmodule
